[sv/lfs_pkg.sv]
package lfs_pkg;

  localparam int LED_COUNT    = 5;
  localparam int FINISH_STEPS = 8;
  localparam int PIX_W        = 24;
  localparam int IN_W         = 48;
  localparam int OUT_W        = LED_COUNT * PIX_W;

  // request codes
  localparam logic [2:0] REQ_SET     = 3'd0;
  localparam logic [2:0] REQ_BEAT    = 3'd1;
  localparam logic [2:0] REQ_CORRECT = 3'd2;
  localparam logic [2:0] REQ_ERROR   = 3'd3;
  localparam logic [2:0] REQ_QUERY   = 3'd4;

  // phases
  localparam logic [1:0] PH_STANDBY  = 2'd0;
  localparam logic [1:0] PH_PLAYING  = 2'd1;
  localparam logic [1:0] PH_PAUSED   = 2'd2;
  localparam logic [1:0] PH_FINISHED = 2'd3;

  // register indexes
  localparam logic [2:0] REG_RED     = 3'd0;
  localparam logic [2:0] REG_GREEN   = 3'd1;
  localparam logic [2:0] REG_BLUE    = 3'd2;
  localparam logic [2:0] REG_AMBER   = 3'd3;
  localparam logic [2:0] REG_CORRECT = 3'd4;
  localparam logic [2:0] REG_ERROR   = 3'd5;
  localparam logic [2:0] REG_STEP    = 3'd6;

  // frame render modes
  localparam logic [1:0] MODE_DARK    = 2'd0;
  localparam logic [1:0] MODE_FILL    = 2'd1;
  localparam logic [1:0] MODE_BEAT    = 2'd2;
  localparam logic [1:0] MODE_RAINBOW = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [PIX_W-1:0] color;
    logic [2:0]       head;
    logic [2:0]       led;
  } frame_sel_t;

  function automatic logic [PIX_W-1:0] rainbow_color(input logic [2:0] idx);
    logic [PIX_W-1:0] c;
    case (idx)
      3'd0:    c = {8'd48, 8'd0,  8'd5};
      3'd1:    c = {8'd46, 8'd17, 8'd0};
      3'd2:    c = {8'd38, 8'd35, 8'd0};
      3'd3:    c = {8'd0,  8'd43, 8'd11};
      3'd4:    c = {8'd0,  8'd36, 8'd43};
      default: c = '0;
    endcase
    return c;
  endfunction

  // step to bounce head: 0 1 2 3 4 3 2 1
  function automatic logic [2:0] bounce_head(input logic [2:0] step);
    logic [2:0] h;
    case (step)
      3'd0:    h = 3'd0;
      3'd1:    h = 3'd1;
      3'd2:    h = 3'd2;
      3'd3:    h = 3'd3;
      3'd4:    h = 3'd4;
      3'd5:    h = 3'd3;
      3'd6:    h = 3'd2;
      3'd7:    h = 3'd1;
      default: h = 3'd0;
    endcase
    return h;
  endfunction

  // (led + head) mod 5, both operands below 5
  function automatic logic [2:0] rot_index(input logic [2:0] led, input logic [2:0] head);
    logic [3:0] s;
    s = {1'b0, led} + {1'b0, head};
    if (s >= 4'd5) begin
      s = s - 4'd5;
    end
    return s[2:0];
  endfunction

  // beat mod 5 through reciprocal 205/1024, exact for 8-bit inputs
  function automatic logic [2:0] mod5(input logic [7:0] b);
    logic [15:0] p;
    logic [5:0]  q;
    logic [8:0]  r;
    p = {8'd0, b} * 16'd205;
    q = p[15:10];
    r = {1'b0, b} - ({3'd0, q} * 9'd5);
    return r[2:0];
  endfunction

endpackage

[sv/lfs_alu.sv]
module lfs_alu
  import lfs_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic [31:0] res,
  output logic        borrow
);

  logic [32:0] sum;

  assign sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {32'd0, sub};
  assign res    = sum[31:0];
  assign borrow = sub & ~sum[32];

endmodule

[sv/lfs_pix.sv]
module lfs_pix
  import lfs_pkg::*;
(
  input  frame_sel_t       sel,
  output logic [OUT_W-1:0] frame
);

  always_comb begin
    frame = '0;
    for (int i = 0; i < LED_COUNT; i++) begin
      case (sel.mode)
        MODE_FILL: frame[i*PIX_W +: PIX_W] = sel.color;
        MODE_BEAT: begin
          if (sel.led == 3'(i)) begin
            frame[i*PIX_W +: PIX_W] = sel.color;
          end
        end
        MODE_RAINBOW: frame[i*PIX_W +: PIX_W] = rainbow_color(rot_index(3'(i), sel.head));
        default: frame[i*PIX_W +: PIX_W] = '0;
      endcase
    end
  end

endmodule

[sv/led_feedback_frame_sequencer.sv]
// Channel   | Dir | Signals                    | Payload (low bit up)
// ----------+-----+----------------------------+---------------------------------------------
// request   | in  | s_tvalid s_tready s_tdata  | req_type[2:0] new_phase[4:3] beat_number[12:5]
//           |     |                            | time_ms[44:13], zero [47:45]
// frame     | out | m_tvalid m_tready m_tdata  | pixel_0[23:0] .. pixel_4[119:96]
// config    | in  | cfg_we cfg_addr cfg_wdata  | register index, 24-bit data, no read-back
//
// Steps: one transfer in, then decode; events finish there, standby/paused queries load
// the output, playing queries compare the error then the correct deadline, and finished
// queries compute elapsed time, compare it to the animation and divide for the step.
// The shared 32-bit adder does one compare or one 3-bit restoring divide step per cycle.
// Reset: synchronous, clears phase, deadlines, beat state and loads register defaults.
// Stalls: a finished frame waits in the output register; the next request is
// taken meanwhile, and the sequencer only holds before loading a new frame.
module led_feedback_frame_sequencer
  import lfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // req_type, new_phase, beat_number, time_ms
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // pixel_0 .. pixel_4
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [PIX_W-1:0] cfg_wdata
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;  // decode, correct/error events use the adder
  localparam logic [2:0] S_ERR  = 3'd2;  // error pulse compare
  localparam logic [2:0] S_COR  = 3'd3;  // correct pulse compare
  localparam logic [2:0] S_ELAP = 3'd4;  // elapsed = now - finish_start
  localparam logic [2:0] S_DUR  = 3'd5;  // elapsed vs 8 * step
  localparam logic [2:0] S_DIV  = 3'd6;  // quotient bits 2..0
  localparam logic [2:0] S_OUT  = 3'd7;  // load output register

  logic [2:0]  state;

  // config
  logic [PIX_W-1:0] red_color, green_color, blue_color, amber_color;
  logic [15:0]      correct_pulse_ms, error_pulse_ms, finish_step_ms;

  // block state
  logic [1:0]  phase;
  logic [2:0]  beat_led;
  logic        beat_seen;
  logic [31:0] correct_deadline, error_deadline, finish_start;

  // latched request
  logic [2:0]  req;
  logic [1:0]  np;
  logic [7:0]  beat;
  logic [31:0] now;

  // finished-phase scratch
  logic [31:0] acc;
  logic [2:0]  quo;
  logic [1:0]  cnt;

  frame_sel_t  sel;
  logic [OUT_W-1:0] frame;

  // shared unit operands
  logic [31:0] alu_a, alu_b, alu_res;
  logic        alu_sub, alu_borrow;
  logic        running;
  logic [2:0]  quo_next;

  lfs_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  lfs_pix u_pix (
    .sel   (sel),
    .frame (frame)
  );

  assign s_tready = (state == S_IDLE);
  // pulse runs while (deadline - now) is positive as a signed value
  assign running  = (alu_res != 32'd0) && !alu_res[31];

  always_comb begin
    alu_a   = now;
    alu_b   = 32'd0;
    alu_sub = 1'b1;
    case (state)
      S_DISP: begin
        alu_sub = 1'b0;
        alu_b   = {16'd0, (req == REQ_ERROR) ? error_pulse_ms : correct_pulse_ms};
      end
      S_ERR: begin
        alu_a = error_deadline;
        alu_b = now;
      end
      S_COR: begin
        alu_a = correct_deadline;
        alu_b = now;
      end
      S_ELAP: begin
        alu_b = finish_start;
      end
      S_DUR: begin
        alu_a = acc;
        alu_b = {13'd0, finish_step_ms, 3'd0};
      end
      S_DIV: begin
        alu_a = acc;
        alu_b = {16'd0, finish_step_ms} << cnt;
      end
      default: begin
        alu_a = now;
      end
    endcase
  end

  always_comb begin
    quo_next = quo;
    if (!alu_borrow) begin
      quo_next[cnt] = 1'b1;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      red_color        <= 24'h300000;
      green_color      <= 24'h003000;
      blue_color       <= 24'h000030;
      amber_color      <= 24'h302000;
      correct_pulse_ms <= 16'd150;
      error_pulse_ms   <= 16'd300;
      finish_step_ms   <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RED:     red_color        <= cfg_wdata;
        REG_GREEN:   green_color      <= cfg_wdata;
        REG_BLUE:    blue_color       <= cfg_wdata;
        REG_AMBER:   amber_color      <= cfg_wdata;
        REG_CORRECT: correct_pulse_ms <= cfg_wdata[15:0];
        REG_ERROR:   error_pulse_ms   <= cfg_wdata[15:0];
        REG_STEP:    finish_step_ms   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // request latch and finished scratch: payload, no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req  <= s_tdata[2:0];
      np   <= s_tdata[4:3];
      beat <= s_tdata[12:5];
      now  <= s_tdata[44:13];
    end
    case (state)
      S_ELAP: acc <= alu_res;
      S_DUR: begin
        quo <= 3'd0;
        cnt <= 2'd2;
      end
      S_DIV: begin
        if (!alu_borrow) begin
          acc <= alu_res;
        end
        quo <= quo_next;
        cnt <= cnt - 2'd1;
      end
      default: ;
    endcase
  end

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase            <= PH_STANDBY;
      beat_led         <= 3'd0;
      beat_seen        <= 1'b0;
      correct_deadline <= 32'd0;
      error_deadline   <= 32'd0;
      finish_start     <= 32'd0;
      sel              <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          if (req != REQ_QUERY) begin
            state <= S_IDLE;
          end
          case (req)
            REQ_SET: begin
              phase            <= np;
              correct_deadline <= 32'd0;
              error_deadline   <= 32'd0;
              if (np == PH_FINISHED) begin
                finish_start <= now;
              end
              if (np != PH_PLAYING) begin
                beat_seen <= 1'b0;
              end
            end
            REQ_BEAT: begin
              if (phase == PH_PLAYING) begin
                beat_led  <= mod5(beat);
                beat_seen <= 1'b1;
              end
            end
            REQ_CORRECT: begin
              if (phase == PH_PLAYING) begin
                correct_deadline <= alu_res;
              end
            end
            REQ_ERROR: begin
              if (phase == PH_PLAYING) begin
                error_deadline <= alu_res;
              end
            end
            REQ_QUERY: begin
              // paused is all amber, everything else starts dark
              sel.mode  <= (phase == PH_PAUSED) ? MODE_FILL : MODE_DARK;
              sel.color <= amber_color;
              sel.head  <= 3'd0;
              sel.led   <= beat_led;
              case (phase)
                PH_PLAYING:  state <= S_ERR;
                PH_FINISHED: state <= S_ELAP;
                default:     state <= S_OUT;
              endcase
            end
            default: ;
          endcase
        end
        S_ERR: begin
          if (running) begin
            sel.mode  <= MODE_FILL;
            sel.color <= red_color;
            state     <= S_OUT;
          end else begin
            state <= S_COR;
          end
        end
        S_COR: begin
          state <= S_OUT;
          if (running) begin
            sel.mode  <= MODE_FILL;
            sel.color <= green_color;
          end else begin
            sel.mode  <= beat_seen ? MODE_BEAT : MODE_DARK;
            sel.color <= blue_color;
          end
        end
        S_ELAP: state <= S_DUR;
        S_DUR: begin
          // at or past the full animation (or zero step length): dark
          state <= alu_borrow ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (cnt == 2'd0) begin
            sel.mode <= MODE_RAINBOW;
            sel.head <= bounce_head(quo_next);
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= frame;
    end
  end

endmodule

[sv/lfs_checker.sv]
module lfs_checker
  import lfs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // a stalled frame holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("frame changed or dropped under stall");

  // the block is busy right after taking a request
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // an event never produces a frame
  a_event_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[2:0] != REQ_QUERY) |=> ##1 !$rose(m_tvalid))
    else $error("frame after non-query request");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind led_feedback_frame_sequencer lfs_checker u_lfs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
